[rtl/plc_pkg.sv]
// Shared types and constants for the positional list engine.
// Holds operation and status codes, cell command codes and the cell control struct.
// No dependencies.
package plc_pkg;

  // Data and index widths. IDX_W is wide enough for lengths up to 127.
  localparam int DATA_W = 32;
  localparam int IDX_W  = 7;

  // Operation codes on in_operation
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // Status codes on out_status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADINDEX = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Commands broadcast to every cell of the chain
  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_ROTATE = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [IDX_W-1:0]  pos;
    logic [IDX_W-1:0]  len;
    logic [DATA_W-1:0] val;
  } plc_ctrl_t;

endpackage

[rtl/plc_cell.sv]
// One storage cell of the list chain: holds a single entry.
// Takes its left or right neighbor, the new value or the head entry per command.
// Depends on plc_pkg.
module plc_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  plc_pkg::plc_ctrl_t          ctrl,
  input  logic [plc_pkg::DATA_W-1:0]  left_d,
  input  logic [plc_pkg::DATA_W-1:0]  right_d,
  input  logic [plc_pkg::DATA_W-1:0]  head_d,
  output logic [plc_pkg::DATA_W-1:0]  q
);

  localparam int IW = plc_pkg::IDX_W;
  localparam logic [IW-1:0] IDX_V = IW'(IDX);
  localparam logic [IW-1:0] NXT_V = IW'(IDX + 1);

  logic [plc_pkg::DATA_W-1:0] data_r;
  logic [plc_pkg::DATA_W-1:0] data_nxt;

  // Select the next entry from the broadcast command and this cell's index
  always_comb begin
    data_nxt = data_r;
    case (ctrl.cmd)
      plc_pkg::CMD_INSERT: begin
        if (IDX_V == ctrl.pos) begin
          data_nxt = ctrl.val;
        end else if (IDX_V > ctrl.pos) begin
          data_nxt = left_d;
        end
      end
      plc_pkg::CMD_DELETE: begin
        if ((IDX_V >= ctrl.pos) && (NXT_V < ctrl.len)) begin
          data_nxt = right_d;
        end
      end
      plc_pkg::CMD_ROTATE: begin
        if (NXT_V == ctrl.len) begin
          data_nxt = head_d;
        end else if (NXT_V < ctrl.len) begin
          data_nxt = right_d;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

[rtl/positional_list_engine.sv]
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_operation, in_position, in_value
// out_      output     out_valid / out_stall out_status, out_element, out_last
//
// Append, insert and delete update the chain in place: all cells at or beyond the position shift together.
// A read out gives one result per cycle while the output is not stalled, one per entry, by
// rotating the stored entries through the head cell; the list is back in order at the end.
// No new transfer is taken during a read out or while the output register is stalled.
// rst_n is synchronous and clears the length, the sequencer and the output valid.
// Depends on plc_pkg and plc_cell.
module positional_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [4:0]         in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_element,
  output logic               out_last
);

  localparam int IW = plc_pkg::IDX_W;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] CAP_V = IW'(CAPACITY);
  localparam logic [IW-1:0] ONE_V = IW'(1);

  // Sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic          st_r, st_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [31:0]   out_element_r, out_element_nxt;
  logic          out_last_r, out_last_nxt;

  plc_pkg::plc_ctrl_t ctrl;
  logic [plc_pkg::DATA_W-1:0] cell_q [CAPACITY];

  logic          out_free;
  logic          accept;
  logic [IW-1:0] pos_x;
  logic [IW-1:0] len_x;
  logic          full;
  logic          empty;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (st_r == ST_READ) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign pos_x    = IW'(in_position);
  assign len_x    = IW'(len_r);
  assign full     = (len_x == CAP_V);
  assign empty    = (len_r == '0);

  // Decode the operation, drive the cell command and build the result
  always_comb begin
    st_nxt          = st_r;
    cnt_nxt         = cnt_r;
    len_nxt         = len_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_element_nxt = out_element_r;
    out_last_nxt    = out_last_r;
    ctrl.cmd        = plc_pkg::CMD_HOLD;
    ctrl.pos        = pos_x;
    ctrl.len        = len_x;
    ctrl.val        = in_value;

    if (accept) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = plc_pkg::ST_OK;
      out_element_nxt = '0;
      out_last_nxt    = 1'b1;
      case (in_operation)
        plc_pkg::OP_APPEND: begin
          if (full) begin
            out_status_nxt = plc_pkg::ST_FULL;
          end else begin
            ctrl.cmd = plc_pkg::CMD_INSERT;
            ctrl.pos = len_x;
            len_nxt  = len_r + LW'(1);
          end
        end
        plc_pkg::OP_INSERT: begin
          if (pos_x > len_x) begin
            out_status_nxt = plc_pkg::ST_BADINDEX;
          end else if (full) begin
            out_status_nxt = plc_pkg::ST_FULL;
          end else begin
            ctrl.cmd = plc_pkg::CMD_INSERT;
            len_nxt  = len_r + LW'(1);
          end
        end
        plc_pkg::OP_DELETE: begin
          if (empty) begin
            out_status_nxt = plc_pkg::ST_EMPTY;
          end else if (pos_x >= len_x) begin
            out_status_nxt = plc_pkg::ST_BADINDEX;
          end else begin
            ctrl.cmd = plc_pkg::CMD_DELETE;
            len_nxt  = len_r - LW'(1);
          end
        end
        plc_pkg::OP_READ: begin
          if (empty) begin
            out_status_nxt = plc_pkg::ST_EMPTY;
          end else begin
            out_element_nxt = cell_q[0];
            out_last_nxt    = (len_x == ONE_V);
            ctrl.cmd        = plc_pkg::CMD_ROTATE;
            if (len_x != ONE_V) begin
              st_nxt  = ST_READ;
              cnt_nxt = ONE_V;
            end
          end
        end
        default: begin
          out_status_nxt = plc_pkg::ST_OK;
        end
      endcase
    end else if ((st_r == ST_READ) && out_free) begin
      // Emit the head entry and rotate the chain by one
      out_valid_nxt   = 1'b1;
      out_status_nxt  = plc_pkg::ST_OK;
      out_element_nxt = cell_q[0];
      out_last_nxt    = ((cnt_r + ONE_V) == len_x);
      ctrl.cmd        = plc_pkg::CMD_ROTATE;
      cnt_nxt         = cnt_r + ONE_V;
      if ((cnt_r + ONE_V) == len_x) begin
        st_nxt = ST_IDLE;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
  end

  // Chain of storage cells
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [plc_pkg::DATA_W-1:0] left_d;
    logic [plc_pkg::DATA_W-1:0] right_d;

    if (gi == 0) begin : g_first
      assign left_d = in_value;
    end else begin : g_mid_l
      assign left_d = cell_q[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_last
      assign right_d = cell_q[gi];
    end else begin : g_mid_r
      assign right_d = cell_q[gi+1];
    end

    plc_cell #(
      .IDX (gi)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left_d  (left_d),
      .right_d (right_d),
      .head_d  (cell_q[0]),
      .q       (cell_q[gi])
    );
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

endmodule

[tb/positional_list_engine_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_engine: directed list operations, then
// random append/insert/delete/read traffic under varying idle and stall. Uses plc_pkg.
module positional_list_engine_test;

  localparam int CAP            = 16;
  localparam int HOLD_CYCLES    = 120;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               is_last;
  } list_result_t;

  // Shadow list plus the queue of results it predicts
  class list_scoreboard;
    logic signed [31:0] cells[CAP];
    int                 fill;
    list_result_t       waiting[$];
    int                 mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function int length_now();
      return fill;
    endfunction

    function int pending();
      return waiting.size();
    endfunction

    function void add_expected(logic [1:0] st, logic signed [31:0] el, logic lst);
      list_result_t r;
      r.status  = st;
      r.element = el;
      r.is_last = lst;
      waiting.push_back(r);
    endfunction

    // Apply one accepted operation to the shadow list
    function void note_request(logic [1:0] op, logic [4:0] pos, logic signed [31:0] val);
      int i;
      case (op)
        plc_pkg::OP_APPEND: begin
          if (fill >= CAP) begin
            add_expected(plc_pkg::ST_FULL, '0, 1'b1);
          end else begin
            cells[fill] = val;
            fill++;
            add_expected(plc_pkg::ST_OK, '0, 1'b1);
          end
        end
        plc_pkg::OP_INSERT: begin
          if (int'(pos) > fill) begin
            add_expected(plc_pkg::ST_BADINDEX, '0, 1'b1);
          end else if (fill >= CAP) begin
            add_expected(plc_pkg::ST_FULL, '0, 1'b1);
          end else begin
            for (i = fill; i > int'(pos); i--) cells[i] = cells[i-1];
            cells[pos] = val;
            fill++;
            add_expected(plc_pkg::ST_OK, '0, 1'b1);
          end
        end
        plc_pkg::OP_DELETE: begin
          if (fill == 0) begin
            add_expected(plc_pkg::ST_EMPTY, '0, 1'b1);
          end else if (int'(pos) >= fill) begin
            add_expected(plc_pkg::ST_BADINDEX, '0, 1'b1);
          end else begin
            for (i = int'(pos); i + 1 < fill; i++) cells[i] = cells[i+1];
            fill--;
            add_expected(plc_pkg::ST_OK, '0, 1'b1);
          end
        end
        default: begin
          // read out: one result per element, head first
          if (fill == 0) begin
            add_expected(plc_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            for (i = 0; i < fill; i++) add_expected(plc_pkg::ST_OK, cells[i], i + 1 == fill);
          end
        end
      endcase
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check_result(logic [1:0] st, logic signed [31:0] el, logic lst);
      list_result_t r;
      if (waiting.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result with none predicted: status %0d element %0d last %0b",
                   st, el, lst);
        return;
      end
      r = waiting.pop_front();
      if (st !== r.status || el !== r.element || lst !== r.is_last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: expected status %0d element %0d last %0b, got %0d %0d %0b",
                   r.status, r.element, r.is_last, st, el, lst);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [1:0]         in_operation = plc_pkg::OP_APPEND;
  logic [4:0]         in_position  = '0;
  logic signed [31:0] in_value     = '0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_element;
  logic               out_last;

  list_scoreboard sb;
  int unsigned    tx_idle_pct   = 0;
  int unsigned    rx_idle_pct   = 0;
  bit             hold_off_req  = 1'b0;
  bit             hold_off_done = 1'b0;
  bit             growing       = 1'b1;
  int             quiet_cycles  = 0;

  positional_list_engine #(.CAPACITY(CAP)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_position  (in_position),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_element  (out_element),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random stall, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Check result transfers and watch for a hung block
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_status, out_element, out_last);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offer one operation, idling first at random; hold it until the transfer
  task automatic send_item(input logic [1:0] op, input logic [4:0] pos,
                           input logic signed [31:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_value     <= val;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(op, pos, val);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Empty, bad index and full cases, read outs of a partial and the full list, then deletes
  task automatic directed_items();
    send_item(plc_pkg::OP_READ,   5'd0,  '0);
    send_item(plc_pkg::OP_DELETE, 5'd16, '0);
    send_item(plc_pkg::OP_INSERT, 5'd1,  32'sd5);
    send_item(plc_pkg::OP_INSERT, 5'd0,  32'sh8000_0000);
    send_item(plc_pkg::OP_APPEND, 5'd0,  32'sh7fff_ffff);
    send_item(plc_pkg::OP_INSERT, 5'd2,  -32'sd1);
    send_item(plc_pkg::OP_INSERT, 5'd1,  32'sh5555_5555);
    send_item(plc_pkg::OP_READ,   5'd0,  '0);
    send_item(plc_pkg::OP_DELETE, 5'd1,  '0);
    send_item(plc_pkg::OP_DELETE, 5'd3,  '0);
    send_item(plc_pkg::OP_INSERT, 5'd16, 32'sd7);
    repeat (CAP - 3) send_item(plc_pkg::OP_APPEND, 5'd0, $urandom);
    send_item(plc_pkg::OP_APPEND, 5'd0,  32'sd1);
    send_item(plc_pkg::OP_INSERT, 5'd16, 32'sd2);
    send_item(plc_pkg::OP_READ,   5'd0,  '0);
    send_item(plc_pkg::OP_DELETE, 5'd15, '0);
    send_item(plc_pkg::OP_DELETE, 5'd0,  '0);
  endtask

  // Random traffic that sweeps the list between empty and full
  task automatic random_items(input int n);
    int          len;
    int unsigned roll;
    logic [1:0]  op;
    logic [4:0]  pos;
    repeat (n) begin
      len = sb.length_now();
      if (len >= CAP) growing = 1'b0;
      else if (len == 0) growing = 1'b1;
      roll = $urandom_range(99);
      if (roll < 10) begin
        op = plc_pkg::OP_READ;
      end else if ((roll < 70) == growing) begin
        op = $urandom_range(1) ? plc_pkg::OP_APPEND : plc_pkg::OP_INSERT;
      end else begin
        op = plc_pkg::OP_DELETE;
      end
      // mostly legal positions, some out of range
      if ($urandom_range(99) < 85 && op == plc_pkg::OP_INSERT) begin
        pos = 5'($urandom_range(len, 0));
      end else if ($urandom_range(99) < 85 && op == plc_pkg::OP_DELETE && len > 0) begin
        pos = 5'($urandom_range(len - 1, 0));
      end else begin
        pos = 5'($urandom_range(16, 0));
      end
      send_item(op, pos, pick_value());
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    tx_idle_pct = 9;
    rx_idle_pct = 54;
    random_items(150);
    tx_idle_pct = 54;
    rx_idle_pct = 9;
    random_items(150);
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_off_req = 1'b1;
    random_items(150);
    in_valid <= 1'b0;
    // drain outstanding results, then let the block settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
